// ===== design/polymer_bond_force_accumulator_core_defines.svh =====
// Assertion macros for the bond force accumulator core.
// Needs clk and rst_n in scope at the place of use.
`ifndef POLYMER_BOND_FORCE_ACCUMULATOR_CORE_DEFINES_SVH
`define POLYMER_BOND_FORCE_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PBFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbfa: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PBFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbfa: next-cycle check failed");

`endif

// ===== design/pbfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and saturation helpers for the bond force accumulator.
// No dependencies.
package pbfa_pkg;

  localparam int BEADS_DEF  = 256;
  localparam int DIMENSIONS = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_BOND = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FENE      = 2'd3;

  localparam logic [31:0] STIFFNESS_RST = 32'd65536;
  localparam logic [30:0] MAX_EXT_RST   = 31'd65536;

  localparam logic [63:0] CAP_COEF  = 64'h4000_0000_0000_0000;
  localparam logic [63:0] CAP_FORCE = 64'h0000_0000_8000_0000;
  localparam logic [63:0] PEN_SAT   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         end_a;
    logic [7:0]         end_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         bead;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [1:0]         status;
  } out_item_t;

  // min(floor(p / 2^16), cap)
  function automatic logic [63:0] sat_shr16(input logic [127:0] p, input logic [63:0] cap);
    logic [111:0] s;
    s = p[127:16];
    if (s > {48'd0, cap}) return cap;
    return s[63:0];
  endfunction

  // Signed force from a magnitude of at most 2^31 and a sign.
  function automatic logic [31:0] make_force(input logic [31:0] h, input logic neg);
    if (h == 32'd0) return 32'd0;
    if (neg) return 32'(-h);
    if (h[31]) return 32'h7FFF_FFFF;
    return h;
  endfunction

  // 48-bit accumulator add, saturating at 2^47-1 and -2^47.
  function automatic logic [47:0] acc_add(input logic [47:0] acc, input logic [32:0] dv);
    logic [49:0] s;
    s = {{2{acc[47]}}, acc} + {{17{dv[32]}}, dv};
    if (!s[49] && (s[48] || s[47])) return {1'b0, {47{1'b1}}};
    if (s[49] && !(s[48] && s[47])) return {1'b1, 47'd0};
    return s[47:0];
  endfunction

  // Clamp a 48-bit accumulator to 32 bits.
  function automatic logic [31:0] sat32(input logic [47:0] v);
    if (!v[47] && (|v[46:31])) return 32'h7FFF_FFFF;
    if (v[47] && !(&v[46:31])) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

// ===== design/polymer_bond_force_accumulator_core.sv =====
`timescale 1ns / 1ps
// Bond spring force engine: position store, force accumulators, shared mul/div units.
// Busy from the accepting edge through a load, a readout or a bond (zero length, harmonic,
// overstretched or FENE in range); readout and bond results strobe as busy drops.
// Bond time is set by up to two divisions, a 33-step root and up to twelve multiplies.
// One item at a time; the receiver cannot stall out_valid. Reset starts a pass that
// zeroes the accumulators (busy high). Needs pbfa_pkg, mul, div.
`include "polymer_bond_force_accumulator_core_defines.svh"
module polymer_bond_force_accumulator_core
  import pbfa_pkg::*;
#(
  parameter int BEADS = BEADS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IW = $clog2(BEADS);
  localparam logic [16:0] BEADS_CMP = 17'(BEADS);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_WRAP    = 5'd2;
  localparam logic [4:0] S_RDACC   = 5'd3;
  localparam logic [4:0] S_RDOUT   = 5'd4;
  localparam logic [4:0] S_RDPOS   = 5'd5;
  localparam logic [4:0] S_DIFF    = 5'd6;
  localparam logic [4:0] S_SQ      = 5'd7;
  localparam logic [4:0] S_SQRT    = 5'd8;
  localparam logic [4:0] S_DIVQ    = 5'd9;
  localparam logic [4:0] S_COEF    = 5'd10;
  localparam logic [4:0] S_L2      = 5'd11;
  localparam logic [4:0] S_LEN2    = 5'd12;
  localparam logic [4:0] S_DIVP    = 5'd13;
  localparam logic [4:0] S_HMUL    = 5'd14;
  localparam logic [4:0] S_HPEN    = 5'd15;
  localparam logic [4:0] S_ACCA_RD = 5'd16;
  localparam logic [4:0] S_ACCA_WR = 5'd17;
  localparam logic [4:0] S_ACCB_RD = 5'd18;
  localparam logic [4:0] S_ACCB_WR = 5'd19;

  // configuration
  logic [31:0] k_r;
  logic [30:0] r0_r;
  logic [30:0] lmax_r;
  logic        fene_r;

  // control
  logic [4:0]    state_r;
  logic [IW-1:0] clr_cnt_r;
  logic          launched_r;
  logic [1:0]    axis_r;
  logic [5:0]    sq_cnt_r;

  // item and datapath
  in_item_t    item_r;
  logic [7:0]  a_r;
  logic [7:0]  b_r;
  logic        dneg_r [DIMENSIONS];
  logic [32:0] dm_r [DIMENSIONS];
  logic [31:0] f_r [DIMENSIONS];
  logic [65:0] sum_r;
  logic [65:0] rad_r;
  logic [36:0] rem_r;
  logic [33:0] root_r;
  logic [33:0] len_r;
  logic        mneg_r;
  logic [47:0] mabs_r;
  logic [62:0] c_r;
  logic        over_r;
  logic [1:0]  status_r;
  logic [61:0] l2_r;
  logic [61:0] den_r;
  logic [63:0] pen_r;
  logic [31:0] h_r;

  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_force_zero;

  // memories
  logic [95:0]  pos_mem [BEADS];
  logic [143:0] acc_mem [BEADS];
  logic [95:0]  pos_rd_a_r;
  logic [95:0]  pos_rd_b_r;
  logic [143:0] acc_rd_r;

  logic [IW-1:0] idx_a;
  logic [IW-1:0] idx_b;
  logic [IW-1:0] acc_raddr;
  logic          acc_we;
  logic [IW-1:0] acc_waddr;
  logic [143:0]  acc_wdata;
  logic          pos_we;

  // shared arithmetic units
  logic         is_mul;
  logic         is_div;
  logic         mul_go;
  logic         div_go;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [127:0] mul_prod;
  logic [79:0]  div_dvd;
  logic [63:0]  div_dvs;
  logic         div_done;
  logic [79:0]  div_quo;

  logic [32:0] diff_w [DIMENSIONS];
  logic [32:0] mag_w [DIMENSIONS];
  logic [65:0] sum_nxt;
  logic [36:0] rem_s;
  logic [36:0] trial;
  logic        sq_fit;
  logic [36:0] rem_nxt;
  logic [33:0] root_nxt;
  logic [47:0] q_w;
  logic [63:0] sat_h;
  logic [63:0] sat_c;
  logic [31:0] h_fin;
  logic [31:0] f_cur;
  logic        over_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign idx_a     = IW'(a_r);
  assign idx_b     = IW'(b_r);
  assign acc_raddr = (state_r == S_ACCB_RD) ? idx_b : idx_a;
  assign pos_we    = (state_r == S_WRAP) && !(17'(a_r) >= BEADS_CMP)
                     && !(17'(b_r) >= BEADS_CMP) && (item_r.func == FUNC_LOAD);

  // configuration writes: accepted whenever offered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= STIFFNESS_RST;
      r0_r   <= 31'd0;
      lmax_r <= MAX_EXT_RST;
      fene_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STIFFNESS: k_r    <= cfg_data;
        CFG_REST_LEN:  r0_r   <= cfg_data[30:0];
        CFG_MAX_EXT:   lmax_r <= cfg_data[30:0];
        CFG_FENE:      fene_r <= cfg_data[0];
        default:       k_r    <= k_r;
      endcase
    end
  end

  // position store: one write port, two registered reads
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[idx_a] <= {item_r.pos_z, item_r.pos_y, item_r.pos_x};
    end
    pos_rd_a_r <= pos_mem[idx_a];
    pos_rd_b_r <= pos_mem[idx_b];
  end

  // accumulator store: one write port, one registered read
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd_r <= acc_mem[acc_raddr];
  end

  // accumulator write side: clear pass, readout clear, read-modify-write of both ends
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = idx_a;
    acc_wdata = 144'd0;
    case (state_r)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_cnt_r;
      end
      S_RDOUT: begin
        acc_we = 1'b1;
      end
      S_ACCA_WR: begin
        acc_we = 1'b1;
        for (int i = 0; i < DIMENSIONS; i++) begin
          acc_wdata[48*i +: 48] = acc_add(acc_rd_r[48*i +: 48], 33'(-{f_r[i][31], f_r[i]}));
        end
      end
      S_ACCB_WR: begin
        acc_we    = 1'b1;
        acc_waddr = idx_b;
        for (int i = 0; i < DIMENSIONS; i++) begin
          acc_wdata[48*i +: 48] = acc_add(acc_rd_r[48*i +: 48], {f_r[i][31], f_r[i]});
        end
      end
      default: acc_we = 1'b0;
    endcase
  end

  // operand steering for the shared multiplier and divider
  always_comb begin
    is_mul  = 1'b0;
    is_div  = 1'b0;
    mul_a   = 64'd0;
    mul_b   = 64'd0;
    div_dvd = 80'd0;
    div_dvs = 64'd0;
    case (state_r)
      S_SQ: begin
        is_mul = 1'b1;
        mul_a  = 64'(dm_r[axis_r]);
        mul_b  = 64'(dm_r[axis_r]);
      end
      S_COEF: begin
        is_mul = 1'b1;
        mul_a  = 64'(k_r);
        mul_b  = 64'(mabs_r);
      end
      S_L2: begin
        is_mul = 1'b1;
        mul_a  = 64'(lmax_r);
        mul_b  = 64'(lmax_r);
      end
      S_LEN2: begin
        is_mul = 1'b1;
        mul_a  = 64'(len_r);
        mul_b  = 64'(len_r);
      end
      S_HMUL: begin
        is_mul = 1'b1;
        mul_a  = 64'(c_r);
        mul_b  = 64'(dm_r[axis_r]);
      end
      S_HPEN: begin
        is_mul = 1'b1;
        mul_a  = 64'(h_r);
        mul_b  = pen_r;
      end
      S_DIVQ: begin
        is_div  = 1'b1;
        div_dvd = 80'({r0_r, 16'd0});
        div_dvs = 64'(len_r);
      end
      S_DIVP: begin
        is_div  = 1'b1;
        div_dvd = 80'({l2_r, 16'd0});
        div_dvs = 64'(den_r);
      end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_go = is_mul && !launched_r;
  assign div_go = is_div && !launched_r;

  pbfa_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mul_go),
    .op_a     (mul_a),
    .op_b     (mul_b),
    .done     (mul_done),
    .prod     (mul_prod)
  );

  pbfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // separation per axis from the two position rows
  always_comb begin
    for (int i = 0; i < DIMENSIONS; i++) begin
      diff_w[i] = {pos_rd_a_r[32*i+31], pos_rd_a_r[32*i +: 32]}
                - {pos_rd_b_r[32*i+31], pos_rd_b_r[32*i +: 32]};
      mag_w[i]  = diff_w[i][32] ? 33'(-diff_w[i]) : diff_w[i];
    end
  end

  assign sum_nxt = sum_r + mul_prod[65:0];

  // one root bit per cycle
  assign rem_s    = {rem_r[34:0], rad_r[65:64]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign sq_fit   = rem_s >= trial;
  assign rem_nxt  = sq_fit ? rem_s - trial : rem_s;
  assign root_nxt = {root_r[32:0], sq_fit};

  assign q_w    = div_quo[47:0];
  assign sat_c  = sat_shr16(mul_prod, CAP_COEF);
  assign sat_h  = sat_shr16(mul_prod, CAP_FORCE);
  assign over_w = fene_r && (len_r >= 34'(lmax_r));

  // magnitude for the axis that finishes this cycle
  always_comb begin
    h_fin = sat_h[31:0];
    if (state_r == S_HMUL && fene_r && over_r) begin
      h_fin = (sat_h != 64'd0) ? 32'h8000_0000 : 32'd0;
    end
  end
  assign f_cur = make_force(h_fin, mneg_r == dneg_r[axis_r]);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      axis_r      <= 2'd0;
      sq_cnt_r    <= 6'd0;
    end else begin
      out_valid_r <= 1'b0;
      if (mul_go || div_go) begin
        launched_r <= 1'b1;
      end
      if (mul_done || div_done) begin
        launched_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IW'(BEADS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_r  <= in_item;
            a_r     <= in_item.end_a;
            b_r     <= in_item.end_b;
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          // wrap bead indices into range, one subtraction per cycle
          if (17'(a_r) >= BEADS_CMP) begin
            a_r <= a_r - 8'(BEADS);
          end
          if (17'(b_r) >= BEADS_CMP) begin
            b_r <= b_r - 8'(BEADS);
          end
          if (!(17'(a_r) >= BEADS_CMP) && !(17'(b_r) >= BEADS_CMP)) begin
            case (item_r.func)
              FUNC_READ: state_r <= S_RDACC;
              FUNC_BOND: state_r <= S_RDPOS;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_RDACC: state_r <= S_RDOUT;
        S_RDOUT: begin
          out_valid_r        <= 1'b1;
          out_item_r.bead    <= item_r.end_a;
          out_item_r.force_x <= sat32(acc_rd_r[47:0]);
          out_item_r.force_y <= sat32(acc_rd_r[95:48]);
          out_item_r.force_z <= sat32(acc_rd_r[143:96]);
          out_item_r.status  <= ST_OK;
          state_r            <= S_IDLE;
        end
        S_RDPOS: state_r <= S_DIFF;
        S_DIFF: begin
          for (int i = 0; i < DIMENSIONS; i++) begin
            dneg_r[i] <= diff_w[i][32];
            dm_r[i]   <= mag_w[i];
          end
          sum_r   <= 66'd0;
          axis_r  <= 2'd0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (mul_done) begin
            sum_r  <= sum_nxt;
            axis_r <= axis_r + 2'd1;
            if (axis_r == 2'd2) begin
              rad_r    <= sum_nxt;
              rem_r    <= 37'd0;
              root_r   <= 34'd0;
              sq_cnt_r <= 6'd0;
              state_r  <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          rem_r    <= rem_nxt;
          root_r   <= root_nxt;
          rad_r    <= {rad_r[63:0], 2'b00};
          sq_cnt_r <= sq_cnt_r + 6'd1;
          if (sq_cnt_r == 6'd32) begin
            len_r <= root_nxt;
            if (root_nxt == 34'd0) begin
              // zero length: no force, flag it, accumulators keep their value
              for (int i = 0; i < DIMENSIONS; i++) begin
                f_r[i] <= 32'd0;
              end
              status_r <= ST_ZERO;
              state_r  <= S_ACCA_RD;
            end else begin
              state_r <= S_DIVQ;
            end
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            mneg_r  <= q_w > 48'd65536;
            mabs_r  <= (q_w > 48'd65536) ? q_w - 48'd65536 : 48'd65536 - q_w;
            state_r <= S_COEF;
          end
        end
        S_COEF: begin
          if (mul_done) begin
            c_r      <= sat_c[62:0];
            over_r   <= over_w;
            status_r <= over_w ? ST_OVER : ST_OK;
            axis_r   <= 2'd0;
            state_r  <= (fene_r && !over_w) ? S_L2 : S_HMUL;
          end
        end
        S_L2: begin
          if (mul_done) begin
            l2_r    <= mul_prod[61:0];
            state_r <= S_LEN2;
          end
        end
        S_LEN2: begin
          if (mul_done) begin
            den_r   <= l2_r - mul_prod[61:0];
            state_r <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_done) begin
            pen_r   <= (|div_quo[79:63]) ? PEN_SAT : div_quo[63:0];
            state_r <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (mul_done) begin
            if (fene_r && !over_r) begin
              h_r     <= sat_h[31:0];
              state_r <= S_HPEN;
            end else begin
              f_r[axis_r] <= f_cur;
              axis_r      <= axis_r + 2'd1;
              if (axis_r == 2'd2) begin
                state_r <= S_ACCA_RD;
              end
            end
          end
        end
        S_HPEN: begin
          if (mul_done) begin
            f_r[axis_r] <= f_cur;
            axis_r      <= axis_r + 2'd1;
            state_r     <= (axis_r == 2'd2) ? S_ACCA_RD : S_HMUL;
          end
        end
        S_ACCA_RD: state_r <= S_ACCA_WR;
        S_ACCA_WR: state_r <= S_ACCB_RD;
        S_ACCB_RD: state_r <= S_ACCB_WR;
        S_ACCB_WR: begin
          out_valid_r        <= 1'b1;
          out_item_r.bead    <= item_r.end_a;
          out_item_r.force_x <= f_r[0];
          out_item_r.force_y <= f_r[1];
          out_item_r.force_z <= f_r[2];
          out_item_r.status  <= status_r;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_force_zero = (out_item_r.force_x == 32'sd0) && (out_item_r.force_y == 32'sd0)
                          && (out_item_r.force_z == 32'sd0);

  `PBFA_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r)
  `PBFA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `PBFA_ASSERT_NXT(a_single_strobe, out_valid_r, !out_valid_r)
  `PBFA_ASSERT_IMP(a_zero_len_force, out_valid_r && out_item_r.status == ST_ZERO, out_force_zero)

endmodule

// ===== design/pbfa_mul.sv =====
`timescale 1ns / 1ps
// Iterative 64x64 unsigned multiplier, 16 multiplier bits per cycle.
// Depends on nothing but the clock and reset.
module pbfa_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [63:0]  op_a,
  input  logic [63:0]  op_b,
  output logic         done,
  output logic [127:0] prod
);

  logic         busy_r;
  logic         done_r;
  logic [1:0]   step_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic [79:0]  part;
  logic [127:0] acc_nxt;

  assign part    = a_r * b_r[15:0];
  assign acc_nxt = acc_r + (128'(part) << {step_r, 4'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      b_r   <= {16'd0, b_r[63:16]};
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== design/pbfa_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, 80-bit dividend by 64-bit divisor, one quotient bit a cycle.
// Depends on nothing but the clock and reset.
module pbfa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [79:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [79:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [79:0] dvd_r;
  logic [63:0] dvs_r;
  logic [64:0] rem_r;
  logic [64:0] rem_s;
  logic        fits;

  assign rem_s = {rem_r[63:0], dvd_r[79]};
  assign fits  = rem_s >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= 65'd0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_s - {1'b0, dvs_r} : rem_s;
      dvd_r <= {dvd_r[78:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
